/* sv/priority_task_picker_core_macros.svh */
// assertion macros for the priority task picker
`ifndef PRIORITY_TASK_PICKER_CORE_MACROS_SVH
`define PRIORITY_TASK_PICKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// expression must hold at every edge out of reset
`define PTP_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");

// same-cycle implication
`define PTP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define PTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define PTP_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define PTP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/ptp_pkg.sv */
package ptp_pkg;

    localparam int KEY_W   = 64;
    localparam int PRI_W   = 4;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int LEFT_W  = 6;

    typedef enum logic [1:0] {
        ST_ADDED  = 2'd0,
        ST_FULL   = 2'd1,
        ST_PICKED = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_ADD       = 4'b0010,
        S_PICK      = 4'b0100,
        S_PICK_DONE = 4'b1000
    } t_state;

endpackage

/* sv/priority_task_picker_core.sv */
// Pending-task table of a non-preemptive priority scheduler. An add item
// (op 0) stores name key, priority and burst in the lowest free slot, or
// reports the table full. A pick item (op 1) removes the task with the
// highest priority, ties going to the smallest name key and then the lowest
// slot, adds its burst to the 32-bit elapsed time and returns it; an empty
// table reports empty. Every item gives exactly one result. One item is
// worked on at a time and o_stall stays high until its result is loaded
// into the output register. A pick walks the slot memory one entry per cycle
// through a single comparator. An add scans the valid bits one per cycle from
// slot 0. Full and empty are known from the fill count. The next item is
// accepted the cycle after a result is loaded, even while that result still
// waits under i_stall.
`include "priority_task_picker_core_macros.svh"

module priority_task_picker_core
    import ptp_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int NAME_BYTES  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [KEY_W-1:0]   i_name_key,
    input  logic [PRI_W-1:0]   i_task_priority,
    input  logic [BURST_W-1:0] i_burst_length,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [KEY_W-1:0]   o_out_name_key,
    output logic [PRI_W-1:0]   o_out_priority,
    output logic [BURST_W-1:0] o_out_burst,
    output logic [TIME_W-1:0]  o_elapsed_time,
    output logic [LEFT_W-1:0]  o_tasks_left
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = 8 * NAME_BYTES;
    localparam logic [CW-1:0] DepthC  = CW'(TABLE_DEPTH);
    localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic [NW-1:0]      name;
        logic [PRI_W-1:0]   pri;
        logic [BURST_W-1:0] burst;
    } t_slot;

    // control state
    t_state                  r_state, n_state;
    logic [TABLE_DEPTH-1:0]  r_valid, n_valid;
    logic [CW-1:0]           r_count, n_count;
    logic [TIME_W-1:0]       r_time, n_time;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_cmp_vld, n_cmp_vld;
    logic                    r_found, n_found;
    logic                    r_o_valid, n_o_valid;

    // payload
    t_slot                   r_in, n_in;
    t_slot                   r_best, n_best;
    logic [IW-1:0]           r_best_idx, n_best_idx;
    logic [IW-1:0]           r_cmp_idx, n_cmp_idx;
    t_slot                   r_rd;
    t_slot                   r_mem [TABLE_DEPTH];

    logic [1:0]              r_o_status;
    logic [KEY_W-1:0]        r_o_name;
    logic [PRI_W-1:0]        r_o_pri;
    logic [BURST_W-1:0]      r_o_burst;
    logic [TIME_W-1:0]       r_o_time;
    logic [LEFT_W-1:0]       r_o_left;

    logic                    out_free;
    logic                    load;
    t_status                 ld_status;
    logic [KEY_W-1:0]        ld_name;
    logic [PRI_W-1:0]        ld_pri;
    logic [BURST_W-1:0]      ld_burst;
    logic                    mem_we;
    logic                    mem_re;
    logic                    take;

    assign out_free = !r_o_valid || !i_stall;

    // candidate beats the running best
    assign take = r_valid[r_cmp_idx] &&
                  (!r_found || (r_rd.pri > r_best.pri) ||
                   ((r_rd.pri == r_best.pri) && (r_rd.name < r_best.name)));

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_count    = r_count;
        n_time     = r_time;
        n_idx      = r_idx;
        n_cmp_vld  = r_cmp_vld;
        n_found    = r_found;
        n_in       = r_in;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_cmp_idx  = r_cmp_idx;
        load       = 1'b0;
        ld_status  = ST_ADDED;
        ld_name    = '0;
        ld_pri     = '0;
        ld_burst   = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in.name  = i_name_key[KEY_W-1 -: NW];
                    n_in.pri   = i_task_priority;
                    n_in.burst = i_burst_length;
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_cmp_vld  = 1'b0;
                    n_state    = i_op ? S_PICK : S_ADD;
                end
            end
            S_ADD: begin
                if (r_count == DepthC) begin
                    if (out_free) begin
                        load      = 1'b1;
                        ld_status = ST_FULL;
                        n_state   = S_IDLE;
                    end
                end else if (!r_valid[r_idx[IW-1:0]]) begin
                    if (out_free) begin
                        mem_we                 = 1'b1;
                        n_valid[r_idx[IW-1:0]] = 1'b1;
                        n_count                = r_count + 1'b1;
                        load                   = 1'b1;
                        ld_status              = ST_ADDED;
                        n_state                = S_IDLE;
                    end
                end else begin
                    // a free slot exists, so the index stays in range
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PICK: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        load      = 1'b1;
                        ld_status = ST_EMPTY;
                        n_state   = S_IDLE;
                    end
                end else begin
                    // read is issued in the cycle before its compare
                    mem_re    = (r_idx < DepthC);
                    n_cmp_vld = mem_re;
                    n_cmp_idx = r_idx[IW-1:0];
                    if (mem_re) begin
                        n_idx = r_idx + 1'b1;
                    end
                    if (r_cmp_vld && take) begin
                        n_best     = r_rd;
                        n_best_idx = r_cmp_idx;
                        n_found    = 1'b1;
                    end
                    if (r_cmp_vld && (r_cmp_idx == LastIdx)) begin
                        n_state = S_PICK_DONE;
                    end
                end
            end
            S_PICK_DONE: begin
                if (out_free) begin
                    n_valid[r_best_idx] = 1'b0;
                    n_count             = r_count - 1'b1;
                    n_time              = r_time + TIME_W'(r_best.burst);
                    load                = 1'b1;
                    ld_status           = ST_PICKED;
                    ld_name             = KEY_W'(r_best.name) << (KEY_W - NW);
                    ld_pri              = r_best.pri;
                    ld_burst            = r_best.burst;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_time    <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_time    <= n_time;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_found   <= n_found;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_cmp_idx  <= n_cmp_idx;
        if (load) begin
            r_o_status <= ld_status;
            r_o_name   <= ld_name;
            r_o_pri    <= ld_pri;
            r_o_burst  <= ld_burst;
            r_o_time   <= n_time;
            r_o_left   <= LEFT_W'(n_count);
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx[IW-1:0]] <= r_in;
        end
        if (mem_re) begin
            r_rd <= r_mem[r_idx[IW-1:0]];
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_out_name_key = r_o_name;
    assign o_out_priority = r_o_pri;
    assign o_out_burst    = r_o_burst;
    assign o_elapsed_time = r_o_time;
    assign o_tasks_left   = r_o_left;

    `PTP_ASSERT_ALWAYS(a_count_matches_valid, i_clk, i_rst_n,
                       $countones(r_valid) == r_count)
    `PTP_ASSERT_ALWAYS(a_count_bounded, i_clk, i_rst_n, r_count <= DepthC)
    `PTP_ASSERT_IMPLY(a_add_idx_in_range, i_clk, i_rst_n, r_state == S_ADD,
                      r_idx < DepthC)
    `PTP_ASSERT_IMPLY(a_pick_has_best, i_clk, i_rst_n, r_state == S_PICK_DONE,
                      r_found && r_valid[r_best_idx])
    `PTP_ASSERT_NEXT(a_pick_frees_slot, i_clk, i_rst_n,
                     (r_state == S_PICK_DONE) && out_free,
                     !r_valid[$past(r_best_idx)])

endmodule
